>>> rtl/hbm_pkg.sv
// Shared types, codes and the microprogram of the handheld bus memory map.
// No dependencies; every other file in rtl/ uses this package by scoped names.
`default_nettype none

package hbm_pkg;

  localparam int unsigned SHADOW_BYTES_DEF = 256;
  localparam int unsigned BUS_DEPTH        = 65536;
  localparam int unsigned BYTE_W           = 8;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [15:0] write_data;
  } hbm_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        tile_dirty;
  } hbm_out_t;

  localparam logic [2:0] ACT_READ_BYTE   = 3'd0;
  localparam logic [2:0] ACT_WRITE_BYTE  = 3'd1;
  localparam logic [2:0] ACT_READ_WORD   = 3'd2;
  localparam logic [2:0] ACT_WRITE_WORD  = 3'd3;
  localparam logic [2:0] ACT_RAW_LOAD    = 3'd4;
  localparam logic [2:0] ACT_SHADOW_LOAD = 3'd5;
  localparam logic [2:0] ACT_CLEAR_DIRTY = 3'd6;

  localparam logic [15:0] ECHO_LO   = 16'hE000;
  localparam logic [15:0] ECHO_HI   = 16'hFE00;
  localparam logic [15:0] ECHO_OFS  = 16'h2000;
  localparam logic [15:0] VRAM_LO   = 16'h8000;
  localparam logic [15:0] VRAM_HI   = 16'hA000;
  localparam logic [15:0] SER_DATA  = 16'hFF01;
  localparam logic [15:0] SER_CTRL  = 16'hFF02;
  localparam logic [15:0] TIMER_DIV = 16'hFF04;
  localparam logic [15:0] BOOT_OFF  = 16'hFF50;
  localparam int unsigned SER_START_BIT = 7;

  localparam int unsigned PWR_COUNT = 28;
  localparam logic [4:0]  PWR_LAST  = 5'(PWR_COUNT - 1);

  // microprogram step addresses
  typedef enum logic [3:0] {
    ST_IDLE, ST_RB0, ST_RB1, ST_RW0, ST_RW1, ST_RW2, ST_BW0, ST_BW1,
    ST_CP0, ST_CP1, ST_PW0, ST_RAW0, ST_SL0, ST_SL1, ST_CLR0, ST_NOP
  } hbm_step_t;

  typedef enum logic [1:0] {BRD_NONE, BRD_CUR, BRD_SER} hbm_brd_t;
  typedef enum logic [2:0] {BWR_NONE, BWR_CUR, BWR_ECHO, BWR_RAW, BWR_COPY, BWR_PWR} hbm_bwr_t;
  typedef enum logic [1:0] {SH_NONE, SH_WRITE, SH_READ} hbm_sh_t;
  typedef enum logic [1:0] {CAP_NONE, CAP_LO, CAP_HI, CAP_SER} hbm_cap_t;
  typedef enum logic [1:0] {FLG_NONE, FLG_VIDEO, FLG_CLR} hbm_flg_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} hbm_cnt_t;
  typedef enum logic [1:0] {CND_NEVER, CND_UNMAP, CND_COPY, CND_PWR} hbm_cnd_t;
  typedef enum logic [1:0] {END_NEXT, END_DONE, END_RET} hbm_end_t;

  typedef struct packed {
    hbm_brd_t  brd;
    hbm_bwr_t  bwr;
    hbm_sh_t   sh;
    hbm_cap_t  cap;
    hbm_flg_t  flg;
    logic      cur_hi;
    hbm_cnt_t  cnt;
    hbm_cnt_t  pidx;
    hbm_cnd_t  cnd;
    hbm_step_t target;
    hbm_end_t  fin;
  } hbm_uword_t;

  typedef struct packed {
    hbm_uword_t uw;
    logic       run;
    logic       dispatch;
    logic       ret;
    logic       finish;
  } hbm_ctl_t;

  typedef struct packed {
    logic unmap;
    logic copy_more;
    logic pwr_more;
    logic pending;
    logic out_full;
  } hbm_status_t;

  localparam hbm_uword_t UW_NOP = '{
    brd: BRD_NONE, bwr: BWR_NONE, sh: SH_NONE, cap: CAP_NONE, flg: FLG_NONE,
    cur_hi: 1'b0, cnt: CNT_HOLD, pidx: CNT_HOLD, cnd: CND_NEVER,
    target: ST_IDLE, fin: END_NEXT
  };

  function automatic hbm_uword_t hbm_ucode(input hbm_step_t step);
    hbm_uword_t w;
    w = UW_NOP;
    case (step)
      ST_RB0:  w.brd = BRD_CUR;
      ST_RB1: begin
        w.cap = CAP_LO;
        w.fin = END_DONE;
      end
      ST_RW0: begin
        w.brd    = BRD_CUR;
        w.cur_hi = 1'b1;
      end
      ST_RW1: begin
        w.cap = CAP_LO;
        w.brd = BRD_CUR;
      end
      ST_RW2: begin
        w.cap = CAP_HI;
        w.fin = END_DONE;
      end
      ST_BW0: begin
        w.bwr = BWR_CUR;
        w.brd = BRD_SER;
        w.flg = FLG_VIDEO;
      end
      ST_BW1: begin
        w.bwr    = BWR_ECHO;
        w.cap    = CAP_SER;
        w.cnt    = CNT_CLR;
        w.pidx   = CNT_CLR;
        w.cnd    = CND_UNMAP;
        w.target = ST_CP0;
        w.fin    = END_RET;
      end
      ST_CP0: begin
        w.sh  = SH_READ;
        w.cnt = CNT_INC;
      end
      ST_CP1: begin
        w.bwr    = BWR_COPY;
        w.sh     = SH_READ;
        w.cnt    = CNT_INC;
        w.cnd    = CND_COPY;
        w.target = ST_CP1;
      end
      ST_PW0: begin
        w.bwr    = BWR_PWR;
        w.pidx   = CNT_INC;
        w.cnd    = CND_PWR;
        w.target = ST_PW0;
        w.fin    = END_RET;
      end
      ST_RAW0: begin
        w.bwr = BWR_RAW;
        w.fin = END_DONE;
      end
      ST_SL0:  w.fin = END_NEXT;
      ST_SL1: begin
        w.sh  = SH_WRITE;
        w.fin = END_DONE;
      end
      ST_CLR0: begin
        w.flg = FLG_CLR;
        w.fin = END_DONE;
      end
      ST_NOP:  w.fin = END_DONE;
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

  function automatic hbm_step_t hbm_entry(input logic [2:0] action);
    hbm_step_t s;
    case (action)
      ACT_READ_BYTE:   s = ST_RB0;
      ACT_WRITE_BYTE:  s = ST_BW0;
      ACT_READ_WORD:   s = ST_RW0;
      ACT_WRITE_WORD:  s = ST_BW0;
      ACT_RAW_LOAD:    s = ST_RAW0;
      ACT_SHADOW_LOAD: s = ST_SL0;
      ACT_CLEAR_DIRTY: s = ST_CLR0;
      default:         s = ST_NOP;
    endcase
    return s;
  endfunction

  // power-up register image written after the boot shadow copy
  function automatic logic [15:0] hbm_pwr_addr(input logic [4:0] idx);
    logic [15:0] a;
    case (idx)
      5'd0:  a = 16'hFF10;
      5'd1:  a = 16'hFF11;
      5'd2:  a = 16'hFF12;
      5'd3:  a = 16'hFF14;
      5'd4:  a = 16'hFF16;
      5'd5:  a = 16'hFF17;
      5'd6:  a = 16'hFF19;
      5'd7:  a = 16'hFF1A;
      5'd8:  a = 16'hFF1B;
      5'd9:  a = 16'hFF1C;
      5'd10: a = 16'hFF1E;
      5'd11: a = 16'hFF20;
      5'd12: a = 16'hFF21;
      5'd13: a = 16'hFF22;
      5'd14: a = 16'hFF23;
      5'd15: a = 16'hFF24;
      5'd16: a = 16'hFF25;
      5'd17: a = 16'hFF26;
      5'd18: a = 16'hFF40;
      5'd19: a = 16'hFF42;
      5'd20: a = 16'hFF43;
      5'd21: a = 16'hFF45;
      5'd22: a = 16'hFF47;
      5'd23: a = 16'hFF48;
      5'd24: a = 16'hFF49;
      5'd25: a = 16'hFF4A;
      5'd26: a = 16'hFF4B;
      5'd27: a = 16'hFFFF;
      default: a = 16'hFFFF;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] hbm_pwr_val(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'h80;
      5'd1:  v = 8'hBF;
      5'd2:  v = 8'hF3;
      5'd3:  v = 8'hBF;
      5'd4:  v = 8'h3F;
      5'd5:  v = 8'h00;
      5'd6:  v = 8'hBF;
      5'd7:  v = 8'h7F;
      5'd8:  v = 8'hFF;
      5'd9:  v = 8'h9F;
      5'd10: v = 8'hBF;
      5'd11: v = 8'hFF;
      5'd12: v = 8'h00;
      5'd13: v = 8'h00;
      5'd14: v = 8'hBF;
      5'd15: v = 8'h77;
      5'd16: v = 8'hF3;
      5'd17: v = 8'hF1;
      5'd18: v = 8'h91;
      5'd22: v = 8'hFC;
      5'd23: v = 8'hFF;
      5'd24: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on hbm_pkg for default sizes only.
`default_nettype none

module hbm_ram #(
  parameter int unsigned WIDTH = hbm_pkg::BYTE_W,
  parameter int unsigned DEPTH = hbm_pkg::SHADOW_BYTES_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/hbm_useq.sv
// Microcode sequencer: step counter, control-word rom and branch logic.
// Depends on hbm_pkg (step codes, control word, microprogram).
`default_nettype none

module hbm_useq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           in_action,
  input  hbm_pkg::hbm_status_t st,
  output logic                 in_ready,
  output hbm_pkg::hbm_ctl_t    ctl
);

  hbm_pkg::hbm_step_t  pc_r, pc_nxt;
  hbm_pkg::hbm_uword_t uw;
  logic is_idle, jmp, ret_pt, last, stall, run, dispatch;

  assign uw      = hbm_pkg::hbm_ucode(pc_r);
  assign is_idle = (pc_r == hbm_pkg::ST_IDLE);

  always_comb begin
    case (uw.cnd)
      hbm_pkg::CND_UNMAP: jmp = st.unmap;
      hbm_pkg::CND_COPY:  jmp = st.copy_more;
      hbm_pkg::CND_PWR:   jmp = st.pwr_more;
      default:            jmp = 1'b0;
    endcase
  end

  assign ret_pt = !jmp && (uw.fin == hbm_pkg::END_RET) && st.pending;
  assign last   = !is_idle && !jmp &&
                  ((uw.fin == hbm_pkg::END_DONE) ||
                   ((uw.fin == hbm_pkg::END_RET) && !st.pending));
  // final step waits while the result register is still occupied
  assign stall    = last && st.out_full;
  assign run      = !is_idle && !stall;
  assign in_ready = is_idle || (last && !st.out_full);
  assign dispatch = in_valid && in_ready;

  always_comb begin
    pc_nxt = pc_r;
    if (dispatch) begin
      pc_nxt = hbm_pkg::hbm_entry(in_action);
    end else if (run) begin
      if (jmp) begin
        pc_nxt = uw.target;
      end else if (ret_pt) begin
        pc_nxt = hbm_pkg::ST_BW0;
      end else if (last) begin
        pc_nxt = hbm_pkg::ST_IDLE;
      end else begin
        pc_nxt = hbm_pkg::hbm_step_t'(pc_r + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= hbm_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl.uw       = uw;
  assign ctl.run      = run;
  assign ctl.dispatch = dispatch;
  assign ctl.ret      = run && ret_pt;
  assign ctl.finish   = last && !stall;

endmodule

`default_nettype wire

>>> rtl/hbm_dp.sv
// Datapath: bus store and boot shadow rams, address decode, side effects, result register.
// Depends on hbm_pkg and hbm_ram; driven by the control word from hbm_useq.
`default_nettype none

module hbm_dp #(
  parameter int unsigned SHADOW_BYTES = hbm_pkg::SHADOW_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hbm_pkg::hbm_in_t     in_data,
  input  hbm_pkg::hbm_ctl_t    ctl,
  input  logic                 out_ready,
  output logic                 out_valid,
  output hbm_pkg::hbm_out_t    out_data,
  output hbm_pkg::hbm_status_t st
);

  localparam int unsigned SAW = (SHADOW_BYTES > 1) ? $clog2(SHADOW_BYTES) : 1;
  localparam int unsigned CW  = $clog2(SHADOW_BYTES + 1);
  // ceil(2^31 / SHADOW_BYTES): exact quotient for any 16-bit address
  localparam logic [31:0] SHD_RECIP =
    32'(((64'd1 << 31) + 64'(SHADOW_BYTES) - 64'd1) / 64'(SHADOW_BYTES));

  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  data_lo_r, data_lo_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [7:0]  cur_byte_r, cur_byte_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] rd_r, rd_nxt;
  logic        ser_v_r, ser_v_nxt;
  logic [7:0]  ser_b_r, ser_b_nxt;
  logic        dirty_r, dirty_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [4:0]  pidx_r, pidx_nxt;
  logic [15:0] q_r, q_nxt;
  logic        out_valid_r, out_valid_nxt;
  hbm_pkg::hbm_out_t out_r, out_nxt, res;

  logic        cur_is_echo, cur_is_vram, ser_start, copy_more;
  logic [15:0] cur_map, rem;

  logic        bus_we, bus_re;
  logic [15:0] bus_waddr, bus_raddr;
  logic [7:0]  bus_wdata, bus_rdata;
  logic           shd_we, shd_re;
  logic [SAW-1:0] shd_waddr, shd_raddr;
  logic [7:0]     shd_rdata;

  assign cur_is_echo = (cur_addr_r >= hbm_pkg::ECHO_LO) && (cur_addr_r < hbm_pkg::ECHO_HI);
  assign cur_is_vram = (cur_addr_r >= hbm_pkg::VRAM_LO) && (cur_addr_r < hbm_pkg::VRAM_HI);
  assign cur_map     = cur_is_echo ? (cur_addr_r - hbm_pkg::ECHO_OFS) : cur_addr_r;
  assign ser_start   = (cur_addr_r == hbm_pkg::SER_CTRL) && cur_byte_r[hbm_pkg::SER_START_BIT];
  assign copy_more   = (cnt_r != CW'(SHADOW_BYTES));

  // shadow index: address mod SHADOW_BYTES via reciprocal, quotient registered
  assign q_nxt = 16'((48'(addr_r) * 48'(SHD_RECIP)) >> 31);
  assign rem   = addr_r - 16'(32'(q_r) * 32'(SHADOW_BYTES));

  // bus store ports
  always_comb begin
    bus_we    = 1'b0;
    bus_waddr = cur_addr_r;
    bus_wdata = cur_byte_r;
    if (ctl.run) begin
      case (ctl.uw.bwr)
        hbm_pkg::BWR_CUR: begin
          bus_we = 1'b1;
          if (cur_addr_r == hbm_pkg::TIMER_DIV) begin
            bus_wdata = 8'd0;
          end
        end
        hbm_pkg::BWR_ECHO: begin
          bus_we    = cur_is_echo;
          bus_waddr = cur_addr_r - hbm_pkg::ECHO_OFS;
        end
        hbm_pkg::BWR_RAW: bus_we = 1'b1;
        hbm_pkg::BWR_COPY: begin
          bus_we    = 1'b1;
          bus_waddr = 16'(cnt_r) - 16'd1;
          bus_wdata = shd_rdata;
        end
        hbm_pkg::BWR_PWR: begin
          bus_we    = 1'b1;
          bus_waddr = hbm_pkg::hbm_pwr_addr(pidx_r);
          bus_wdata = hbm_pkg::hbm_pwr_val(pidx_r);
        end
        default: bus_we = 1'b0;
      endcase
    end
  end

  assign bus_re    = ctl.run && (ctl.uw.brd != hbm_pkg::BRD_NONE);
  assign bus_raddr = (ctl.uw.brd == hbm_pkg::BRD_SER) ? hbm_pkg::SER_DATA : cur_map;

  assign shd_we    = ctl.run && (ctl.uw.sh == hbm_pkg::SH_WRITE);
  assign shd_waddr = rem[SAW-1:0];
  assign shd_re    = ctl.run && (ctl.uw.sh == hbm_pkg::SH_READ) && copy_more;
  assign shd_raddr = cnt_r[SAW-1:0];

  hbm_ram #(
    .WIDTH (hbm_pkg::BYTE_W),
    .DEPTH (hbm_pkg::BUS_DEPTH)
  ) u_bus_ram (
    .clk   (clk),
    .we    (bus_we),
    .waddr (bus_waddr),
    .wdata (bus_wdata),
    .re    (bus_re),
    .raddr (bus_raddr),
    .rdata (bus_rdata)
  );

  hbm_ram #(
    .WIDTH (hbm_pkg::BYTE_W),
    .DEPTH (SHADOW_BYTES)
  ) u_shadow_ram (
    .clk   (clk),
    .we    (shd_we),
    .waddr (shd_waddr),
    .wdata (data_lo_r),
    .re    (shd_re),
    .raddr (shd_raddr),
    .rdata (shd_rdata)
  );

  always_comb begin
    addr_nxt     = addr_r;
    data_lo_nxt  = data_lo_r;
    cur_addr_nxt = cur_addr_r;
    cur_byte_nxt = cur_byte_r;
    pending_nxt  = pending_r;
    rd_nxt       = rd_r;
    ser_v_nxt    = ser_v_r;
    ser_b_nxt    = ser_b_r;
    dirty_nxt    = dirty_r;
    cnt_nxt      = cnt_r;
    pidx_nxt     = pidx_r;

    if (ctl.run) begin
      if (ctl.uw.cur_hi) begin
        cur_addr_nxt = addr_r + 16'd1;
      end
      // second half of a word write: low byte at the base address
      if (ctl.ret) begin
        cur_addr_nxt = addr_r;
        cur_byte_nxt = data_lo_r;
        pending_nxt  = 1'b0;
      end
      case (ctl.uw.cap)
        hbm_pkg::CAP_LO: rd_nxt[7:0]  = bus_rdata;
        hbm_pkg::CAP_HI: rd_nxt[15:8] = bus_rdata;
        hbm_pkg::CAP_SER: begin
          if (ser_start) begin
            ser_v_nxt = 1'b1;
            ser_b_nxt = bus_rdata;
          end
        end
        default: rd_nxt = rd_r;
      endcase
      case (ctl.uw.flg)
        hbm_pkg::FLG_VIDEO: begin
          if (cur_is_vram) begin
            dirty_nxt = 1'b1;
          end
        end
        hbm_pkg::FLG_CLR: dirty_nxt = 1'b0;
        default:          dirty_nxt = dirty_r;
      endcase
      case (ctl.uw.cnt)
        hbm_pkg::CNT_CLR: cnt_nxt = '0;
        hbm_pkg::CNT_INC: begin
          if (copy_more) begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        default: cnt_nxt = cnt_r;
      endcase
      case (ctl.uw.pidx)
        hbm_pkg::CNT_CLR: pidx_nxt = 5'd0;
        hbm_pkg::CNT_INC: pidx_nxt = pidx_r + 5'd1;
        default:          pidx_nxt = pidx_r;
      endcase
    end

    res.read_data    = rd_nxt;
    res.serial_valid = ser_v_nxt;
    res.serial_byte  = ser_b_nxt;
    res.tile_dirty   = dirty_nxt;
    out_nxt          = ctl.finish ? res : out_r;
    out_valid_nxt    = ctl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    // a new beat may land in the same cycle as the last step of the previous one
    if (ctl.dispatch) begin
      addr_nxt    = in_data.address;
      data_lo_nxt = in_data.write_data[7:0];
      pending_nxt = (in_data.action == hbm_pkg::ACT_WRITE_WORD);
      if (in_data.action == hbm_pkg::ACT_WRITE_WORD) begin
        cur_addr_nxt = in_data.address + 16'd1;
        cur_byte_nxt = in_data.write_data[15:8];
      end else begin
        cur_addr_nxt = in_data.address;
        cur_byte_nxt = in_data.write_data[7:0];
      end
      rd_nxt    = 16'd0;
      ser_v_nxt = 1'b0;
      ser_b_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      dirty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    data_lo_r  <= data_lo_nxt;
    cur_addr_r <= cur_addr_nxt;
    cur_byte_r <= cur_byte_nxt;
    rd_r       <= rd_nxt;
    ser_v_r    <= ser_v_nxt;
    ser_b_r    <= ser_b_nxt;
    cnt_r      <= cnt_nxt;
    pidx_r     <= pidx_nxt;
    q_r        <= q_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign st.unmap     = (cur_addr_r == hbm_pkg::BOOT_OFF);
  assign st.copy_more = copy_more;
  assign st.pwr_more  = (pidx_r != hbm_pkg::PWR_LAST);
  assign st.pending   = pending_r;
  assign st.out_full  = out_valid_r && !out_ready;

endmodule

`default_nettype wire

>>> rtl/handheld_bus_memory_map.sv
// Top level of the handheld bus memory map: microcode sequencer plus datapath.
// Depends on hbm_pkg, hbm_useq, hbm_dp (which holds the hbm_ram instances).
//
//   channel | ports                           | payload
//   --------+---------------------------------+----------------------------------
//   input   | in_valid, in_ready, in_data     | hbm_in_t  (action, address, data)
//   result  | out_valid, out_ready, out_data  | hbm_out_t (read data, serial, dirty)
//
// steps per beat: read byte RB0, RB1; write byte BW0, BW1; read word RW0 to RW2;
// write word BW0, BW1 for the high byte, then for the low; raw load RAW0; clear
// dirty CLR0; others NOP; shadow load SL0, SL1; 0xFF50 adds boot copy and power-up image.
// all bus traffic shares one write and one read port of the bus store ram.
// the next beat is taken during the last step of the current one.
// reset is synchronous; the rams need no clearing pass.
// the last step of a beat holds while the result register is still full.
`default_nettype none

module handheld_bus_memory_map #(
  parameter int unsigned SHADOW_BYTES = hbm_pkg::SHADOW_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hbm_pkg::hbm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hbm_pkg::hbm_out_t out_data
);

  hbm_pkg::hbm_ctl_t    ctl;
  hbm_pkg::hbm_status_t st;

  hbm_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .st        (st),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  hbm_dp #(
    .SHADOW_BYTES (SHADOW_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

  a_serial_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.serial_valid |-> out_data.serial_byte == 8'd0)
    else $error("serial byte nonzero without serial start");

  a_word_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == hbm_pkg::ACT_WRITE_WORD |=> st.pending)
    else $error("word write did not arm the low byte pass");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctl.finish))
    else $error("result appeared without a finished step");

endmodule

`default_nettype wire

>>> tb/tb_handheld_bus_memory_map.sv
// Self-checking bench for handheld_bus_memory_map: directed and random bus accesses
// checked beat by beat against a behavioral image of the bus store kept here.
// Depends on hbm_pkg and the rtl/ sources of the block.
`timescale 1ns / 1ps

module tb_handheld_bus_memory_map;
  import hbm_pkg::*;

  localparam int SHADOW_N    = SHADOW_BYTES_DEF;
  localparam int N_ITEMS     = 1850;
  localparam int DRAIN_AT    = 1200;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_LEN    = 400;
  localparam int CALM_LO     = 1000;
  localparam int CALM_HI     = 1400;
  localparam int IDLE_PCT    = 16;
  localparam int SETTLE      = SHADOW_N + 64;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [2:0] ACT_NONE = 3'd7;

  typedef struct packed {
    logic    drain_first;
    hbm_in_t beat;
  } access_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  hbm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  hbm_out_t out_data;

  handheld_bus_memory_map dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- bus image
  logic [7:0] mem_model [0:65535];
  logic [7:0] shadow_model [0:SHADOW_N-1];
  logic       dirty_model = 1'b1;
  logic       ser_fire;
  logic [7:0] ser_data;

  logic [15:0] pwr_addr [0:27] = '{
    16'hFF10, 16'hFF11, 16'hFF12, 16'hFF14, 16'hFF16, 16'hFF17, 16'hFF19, 16'hFF1A,
    16'hFF1B, 16'hFF1C, 16'hFF1E, 16'hFF20, 16'hFF21, 16'hFF22, 16'hFF23, 16'hFF24,
    16'hFF25, 16'hFF26, 16'hFF40, 16'hFF42, 16'hFF43, 16'hFF45, 16'hFF47, 16'hFF48,
    16'hFF49, 16'hFF4A, 16'hFF4B, 16'hFFFF};
  // 0xff16 gets 0x3f, 0xff21 gets zero
  logic [7:0] pwr_val [0:27] = '{
    8'h80, 8'hBF, 8'hF3, 8'hBF, 8'h3F, 8'h00, 8'hBF, 8'h7F,
    8'hFF, 8'h9F, 8'hBF, 8'hFF, 8'h00, 8'h00, 8'hBF, 8'h77,
    8'hF3, 8'hF1, 8'h91, 8'h00, 8'h00, 8'h00, 8'hFC, 8'hFF,
    8'hFF, 8'h00, 8'h00, 8'h00};

  function automatic logic in_echo(logic [15:0] a);
    return a >= ECHO_LO && a < ECHO_HI;
  endfunction

  function automatic logic [7:0] peek_bus(logic [15:0] a);
    return mem_model[in_echo(a) ? a - ECHO_OFS : a];
  endfunction

  function automatic void poke_bus(logic [15:0] a, logic [7:0] v);
    mem_model[a] = v;
    if (a >= VRAM_LO && a < VRAM_HI) begin
      dirty_model = 1'b1;
    end else if (in_echo(a)) begin
      mem_model[a - ECHO_OFS] = v;
    end else if (a == SER_CTRL) begin
      if (v[SER_START_BIT]) begin
        ser_fire = 1'b1;
        ser_data = mem_model[SER_DATA];
      end
    end else if (a == TIMER_DIV) begin
      mem_model[a] = 8'h00;
    end else if (a == BOOT_OFF) begin
      for (int i = 0; i < SHADOW_N; i++) mem_model[i] = shadow_model[i];
      foreach (pwr_addr[i]) mem_model[pwr_addr[i]] = pwr_val[i];
    end
  endfunction

  function automatic hbm_out_t predict_access(hbm_in_t b);
    hbm_out_t    r;
    logic [15:0] hi_addr;
    hi_addr  = b.address + 16'd1;
    r        = '0;
    ser_fire = 1'b0;
    ser_data = 8'h00;
    case (b.action)
      ACT_READ_BYTE:  r.read_data = {8'h00, peek_bus(b.address)};
      ACT_WRITE_BYTE: poke_bus(b.address, b.write_data[7:0]);
      ACT_READ_WORD:  r.read_data = {peek_bus(hi_addr), peek_bus(b.address)};
      ACT_WRITE_WORD: begin
        // high byte lands first
        poke_bus(hi_addr, b.write_data[15:8]);
        poke_bus(b.address, b.write_data[7:0]);
      end
      ACT_RAW_LOAD:    mem_model[b.address] = b.write_data[7:0];
      ACT_SHADOW_LOAD: shadow_model[b.address % SHADOW_N] = b.write_data[7:0];
      ACT_CLEAR_DIRTY: dirty_model = 1'b0;
      default: ;
    endcase
    r.serial_valid = ser_fire;
    r.serial_byte  = ser_fire ? ser_data : 8'h00;
    r.tile_dirty   = dirty_model;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  access_t     access_q [$];
  hbm_out_t    pending_results [$];
  logic [15:0] written_addrs [$];
  bit          addr_seen [0:65535];
  bit          slot_seen [0:SHADOW_N-1];
  int          shadow_filled = 0;
  int          queued = 0;

  logic [15:0] spot_addr [0:18] = '{
    16'h0000, 16'h00FF, 16'h0100, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000,
    16'hC000, 16'hDDFF, 16'hDFFF, 16'hE000, 16'hFDFF, 16'hFE00, 16'hFF01,
    16'hFF02, 16'hFF04, 16'hFF4F, 16'hFF50, 16'hFFFF};

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic readable(logic [15:0] a);
    return addr_seen[in_echo(a) ? a - ECHO_OFS : a];
  endfunction

  function automatic void note_byte(logic [15:0] a);
    if (!addr_seen[a]) begin
      addr_seen[a] = 1'b1;
      written_addrs.push_back(a);
    end
  endfunction

  function automatic void note_bus_write(logic [15:0] a);
    note_byte(a);
    if (in_echo(a)) begin
      note_byte(a - ECHO_OFS);
    end else if (a == BOOT_OFF) begin
      for (int i = 0; i < SHADOW_N; i++) note_byte(16'(i));
      foreach (pwr_addr[i]) note_byte(pwr_addr[i]);
    end
  endfunction

  function automatic logic [15:0] known_addr();
    logic [15:0] k;
    k = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    while (!readable(k)) k = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    // sometimes read work ram through its echo
    if (k >= 16'hC000 && k < ECHO_HI - ECHO_OFS && $urandom_range(0, 1) == 1) k = k + ECHO_OFS;
    return k;
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 7))
      0, 1:    return rand16();
      2:       return 16'($urandom_range(0, SHADOW_N - 1));
      3:       return 16'($urandom_range(VRAM_LO, VRAM_HI - 1));
      4:       return 16'($urandom_range(16'hC000, 16'hDFFF));
      5:       return 16'($urandom_range(ECHO_LO, ECHO_HI - 1));
      6:       return 16'($urandom_range(16'hFE00, 16'hFFFF));
      default: return spot_addr[$urandom_range(0, 18)];
    endcase
  endfunction

  // keeps every read on written bytes and holds off the boot unmap
  // until the whole shadow has been loaded
  function automatic void queue_beat(logic [2:0] act, logic [15:0] addr, logic [15:0] data);
    access_t     s;
    logic [15:0] nxt;
    logic [15:0] k;
    nxt = addr + 16'd1;
    if (shadow_filled < SHADOW_N &&
        ((act == ACT_WRITE_BYTE && addr == BOOT_OFF) ||
         (act == ACT_WRITE_WORD && (addr == BOOT_OFF || nxt == BOOT_OFF))))
      act = ACT_RAW_LOAD;
    if (act == ACT_READ_WORD && !(readable(addr) && readable(nxt))) begin
      k = known_addr();
      if (readable(k + 16'd1)) begin
        addr = k;
      end else if (readable(k - 16'd1)) begin
        addr = k - 16'd1;
      end else begin
        act  = ACT_READ_BYTE;
        addr = k;
      end
    end else if (act == ACT_READ_BYTE && !readable(addr)) begin
      addr = known_addr();
    end
    s.drain_first = (queued == DRAIN_AT);
    s.beat = '{action: act, address: addr, write_data: data};
    access_q.push_back(s);
    queued++;
    case (act)
      ACT_WRITE_BYTE: note_bus_write(addr);
      ACT_WRITE_WORD: begin
        note_bus_write(addr + 16'd1);
        note_bus_write(addr);
      end
      ACT_RAW_LOAD: note_byte(addr);
      ACT_SHADOW_LOAD: begin
        if (!slot_seen[addr % SHADOW_N]) begin
          slot_seen[addr % SHADOW_N] = 1'b1;
          shadow_filled++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_unmap();
    queue_beat(ACT_WRITE_BYTE, BOOT_OFF, rand16());
    queue_beat(ACT_READ_BYTE, 16'hFF16, rand16());
    queue_beat(ACT_READ_BYTE, 16'hFF21, rand16());
    queue_beat(ACT_READ_WORD, 16'($urandom_range(0, SHADOW_N - 2)), rand16());
  endfunction

  function automatic void add_directed();
    queue_beat(ACT_RAW_LOAD,    SER_DATA,  16'h00A5);
    queue_beat(ACT_WRITE_BYTE,  16'h0000,  16'hFFFF);
    queue_beat(ACT_WRITE_BYTE,  16'hFFFF,  16'h0000);
    queue_beat(ACT_READ_WORD,   16'hFFFF,  16'h0000);
    queue_beat(ACT_WRITE_WORD,  16'hFFFF,  16'h1234);
    queue_beat(ACT_READ_WORD,   16'hFFFF,  16'hFFFF);
    queue_beat(ACT_CLEAR_DIRTY, 16'h0000,  16'h0000);
    queue_beat(ACT_WRITE_BYTE,  VRAM_LO,   16'h00C3);
    queue_beat(ACT_CLEAR_DIRTY, 16'hFFFF,  16'hFFFF);
    queue_beat(ACT_WRITE_BYTE,  VRAM_HI,   16'h0011);
    queue_beat(ACT_WRITE_BYTE,  16'h9FFF,  16'h0022);
    queue_beat(ACT_WRITE_BYTE,  ECHO_LO,   16'h005A);
    queue_beat(ACT_READ_BYTE,   16'hC000,  16'h0000);
    queue_beat(ACT_WRITE_BYTE,  16'hFDFF,  16'h0066);
    queue_beat(ACT_WRITE_BYTE,  ECHO_HI,   16'h0077);
    queue_beat(ACT_READ_BYTE,   ECHO_HI,   16'h0000);
    queue_beat(ACT_RAW_LOAD,    16'hC010,  16'h0099);
    queue_beat(ACT_READ_BYTE,   16'hE010,  16'h0000);
    queue_beat(ACT_WRITE_BYTE,  TIMER_DIV, 16'h00FF);
    queue_beat(ACT_READ_BYTE,   TIMER_DIV, 16'h0000);
    queue_beat(ACT_WRITE_BYTE,  SER_CTRL,  16'h0081);
    // high byte starts the transfer before the data register changes
    queue_beat(ACT_WRITE_WORD,  SER_DATA,  16'h803C);
    queue_beat(ACT_WRITE_BYTE,  SER_CTRL,  16'h007F);
    queue_beat(ACT_SHADOW_LOAD, 16'hFFFF,  16'h0011);
    queue_beat(ACT_NONE,        16'hFFFF,  16'hFFFF);
  endfunction

  function automatic void add_random();
    int unsigned pick;
    logic [15:0] a;
    logic [15:0] d;
    pick = $urandom_range(0, 99);
    a    = pick_addr();
    d    = rand16();
    if (pick < 18) queue_beat(ACT_READ_BYTE, a, d);
    else if (pick < 28) queue_beat(ACT_READ_WORD, a, d);
    else if (pick < 46) queue_beat(ACT_WRITE_BYTE, a, d);
    else if (pick < 58) queue_beat(ACT_WRITE_WORD, a, d);
    else if (pick < 65) queue_beat(ACT_RAW_LOAD, a, d);
    else if (pick < 70) queue_beat(ACT_SHADOW_LOAD, a, d);
    else if (pick < 73) queue_beat(ACT_CLEAR_DIRTY, a, d);
    else if (pick < 75) queue_beat(ACT_NONE, a, d);
    else if (pick < 83) begin
      // serial transfer: load the data register, then start
      queue_beat($urandom_range(0, 1) ? ACT_WRITE_BYTE : ACT_RAW_LOAD, SER_DATA, rand16());
      if ($urandom_range(0, 3) == 0) begin
        queue_beat(ACT_WRITE_WORD, SER_DATA, d);
      end else begin
        d[SER_START_BIT] = ($urandom_range(0, 3) != 0);
        queue_beat(ACT_WRITE_BYTE, SER_CTRL, d);
      end
      queue_beat(ACT_READ_BYTE, SER_CTRL, rand16());
    end else if (pick < 89) begin
      a = 16'($urandom_range(VRAM_LO, VRAM_HI - 1));
      queue_beat($urandom_range(0, 1) ? ACT_WRITE_BYTE : ACT_WRITE_WORD, a, d);
      queue_beat(ACT_READ_BYTE, a, rand16());
      queue_beat(ACT_CLEAR_DIRTY, rand16(), rand16());
    end else if (pick < 95) begin
      // write one mirror, read back through both
      a = 16'($urandom_range(ECHO_LO, ECHO_HI - 1));
      queue_beat($urandom_range(0, 1) ? ACT_WRITE_BYTE : ACT_WRITE_WORD,
                 $urandom_range(0, 1) ? a : a - ECHO_OFS, d);
      queue_beat(ACT_READ_BYTE, a, rand16());
      queue_beat(ACT_READ_WORD, a - ECHO_OFS, rand16());
    end else if (pick < 97) begin
      add_unmap();
    end else if (pick < 99) begin
      queue_beat(ACT_WRITE_WORD, 16'hFFFF, d);
      queue_beat(ACT_READ_WORD, 16'hFFFF, rand16());
    end else begin
      for (int i = 0; i < 4; i++) queue_beat(ACT_SHADOW_LOAD, rand16(), rand16());
    end
  endfunction

  // ---------------------------------------------------------------- driver
  int      beats_in = 0;
  access_t next_access;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_access(in_data));
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (access_q.size() != 0 &&
            !(access_q[0].drain_first && pending_results.size() != 0) &&
            !((beats_in < CALM_LO || beats_in > CALM_HI) &&
              $urandom_range(0, 99) < IDLE_PCT)) begin
          next_access = access_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_access.beat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int       results_seen = 0;
  int       ready_hold_left = 0;
  bit       hold_done = 1'b0;
  int       err_count = 0;
  hbm_out_t want_beat;

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          err_count++;
        end else begin
          want_beat = pending_results.pop_front();
          check_field("read_data",    want_beat.read_data,    out_data.read_data);
          check_field("serial_valid", want_beat.serial_valid, out_data.serial_valid);
          check_field("serial_byte",  want_beat.serial_byte,  out_data.serial_byte);
          check_field("tile_dirty",   want_beat.tile_dirty,   out_data.tile_dirty);
        end
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (ready_hold_left != 0) begin
        ready_hold_left <= ready_hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done       <= 1'b1;
        ready_hold_left <= HOLD_LEN;
        out_ready       <= 1'b0;
      end else begin
        out_ready <= (results_seen >= CALM_LO && results_seen <= CALM_HI) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("** handheld_bus_memory_map: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    add_directed();
    // whole boot shadow first, so the unmap copies only written bytes
    for (int i = 0; i < SHADOW_N; i++)
      queue_beat(ACT_SHADOW_LOAD,
                 16'($urandom_range(0, 65535 / SHADOW_N) * SHADOW_N + i), rand16());
    add_unmap();
    while (queued < N_ITEMS) add_random();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (beats_in < queued) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("** handheld_bus_memory_map: PASSED **");
    end else begin
      $display("** handheld_bus_memory_map: FAILED **");
    end
    $finish;
  end

endmodule
